// File: rtl/core/dqvs_pkg.sv
// Shared types and codes for the deque with value search.
package dqvs_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;

  // command codes
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_SEARCH     = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] value;
  } dqvs_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         position;
    logic signed [31:0] result_value;
    logic               last;
  } dqvs_out_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_STATUS,
    EMIT_POP,
    EMIT_FINAL
  } dqvs_emit_e;

  // controller -> datapath
  typedef struct packed {
    logic       push_front;
    logic       push_back;
    logic       pop_front;
    logic       pop_back;
    logic       scan_start;
    logic       scan_issue;
    dqvs_emit_e emit;
    logic [1:0] status;
  } dqvs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic last_issue;
  } dqvs_stat_t;

endpackage

// File: rtl/core/dqvs_ctrl.sv
// Command sequencer of the deque with value search.
module dqvs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [2:0]          command_i,
  input  dqvs_pkg::dqvs_stat_t stat_i,
  output dqvs_pkg::dqvs_cmd_t  cmd_o,
  output logic                busy_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_WAIT,
    S_SCAN,
    S_DRAIN,
    S_FIN
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.emit   = dqvs_pkg::EMIT_NONE;
    cmd_o.status = dqvs_pkg::ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (command_i) inside
            dqvs_pkg::CMD_PUSH_FRONT, dqvs_pkg::CMD_PUSH_BACK: begin
              cmd_o.emit = dqvs_pkg::EMIT_STATUS;
              if (stat_i.full) begin
                cmd_o.status = dqvs_pkg::ST_FULL;
              end else begin
                cmd_o.push_front = (command_i == dqvs_pkg::CMD_PUSH_FRONT);
                cmd_o.push_back  = (command_i == dqvs_pkg::CMD_PUSH_BACK);
              end
            end
            dqvs_pkg::CMD_POP_FRONT, dqvs_pkg::CMD_POP_BACK: begin
              if (stat_i.empty) begin
                cmd_o.emit   = dqvs_pkg::EMIT_STATUS;
                cmd_o.status = dqvs_pkg::ST_EMPTY;
              end else begin
                cmd_o.pop_front = (command_i == dqvs_pkg::CMD_POP_FRONT);
                cmd_o.pop_back  = (command_i == dqvs_pkg::CMD_POP_BACK);
                state_d = S_POP_WAIT;
              end
            end
            dqvs_pkg::CMD_SEARCH: begin
              if (stat_i.empty) begin
                cmd_o.emit   = dqvs_pkg::EMIT_STATUS;
                cmd_o.status = dqvs_pkg::ST_NOTFOUND;
              end else begin
                cmd_o.scan_start = 1'b1;
                state_d = S_SCAN;
              end
            end
            default: ; // unused codes: no effect, no beat
          endcase
        end
      end
      S_POP_WAIT: begin
        cmd_o.emit = dqvs_pkg::EMIT_POP;
        state_d = S_IDLE;
      end
      S_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (stat_i.last_issue) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.emit = dqvs_pkg::EMIT_FINAL;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// File: rtl/core/dqvs_dp.sv
// Ring buffer store, pointers, search compare and result register.
module dqvs_dp #(
  parameter int unsigned DEPTH = dqvs_pkg::DEPTH_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic signed [31:0]   value_i,
  input  dqvs_pkg::dqvs_cmd_t  cmd_i,
  output dqvs_pkg::dqvs_stat_t stat_o,
  output logic                 result_valid_o,
  output dqvs_pkg::dqvs_out_t  result_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [31:0]   mem_q [DEPTH];
  logic [IW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] off_q;
  logic [31:0]   rd_data_q;
  logic [31:0]   key_q;
  logic          cmp_valid_q;
  logic [CW-1:0] cmp_pos_q;
  logic          pend_valid_q;
  logic [CW-1:0] pend_pos_q;
  logic [31:0]   pend_val_q;
  logic          out_valid_q, out_valid_d;
  dqvs_pkg::dqvs_out_t out_q, out_d;

  logic          wr_en, rd_en, hit;
  logic [IW-1:0] wr_addr, rd_addr, front_dec, front_inc;

  // front + offset, modulo DEPTH; both terms are below DEPTH
  function automatic logic [IW-1:0] wrap(input logic [IW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return s[IW-1:0];
  endfunction

  assign front_dec = (front_q == '0) ? IW'(DEPTH - 1) : front_q - IW'(1);
  assign front_inc = (front_q == IW'(DEPTH - 1)) ? '0 : front_q + IW'(1);

  assign stat_o.full       = (count_q == CW'(DEPTH));
  assign stat_o.empty      = (count_q == '0);
  assign stat_o.last_issue = (off_q == count_q - CW'(1));

  assign wr_en   = cmd_i.push_front | cmd_i.push_back;
  assign wr_addr = cmd_i.push_front ? front_dec : wrap(front_q, count_q);
  assign rd_en   = cmd_i.pop_front | cmd_i.pop_back | cmd_i.scan_issue;

  always_comb begin
    if (cmd_i.pop_front) begin
      rd_addr = front_q;
    end else if (cmd_i.pop_back) begin
      rd_addr = wrap(front_q, count_q - CW'(1));
    end else begin
      rd_addr = wrap(front_q, off_q);
    end
  end

  always_comb begin
    front_d = front_q;
    count_d = count_q;
    if (cmd_i.push_front) begin
      front_d = front_dec;
      count_d = count_q + CW'(1);
    end else if (cmd_i.push_back) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.pop_front) begin
      front_d = front_inc;
      count_d = count_q - CW'(1);
    end else if (cmd_i.pop_back) begin
      count_d = count_q - CW'(1);
    end
  end

  assign hit = cmp_valid_q && (rd_data_q == key_q);

  always_comb begin
    out_valid_d = 1'b0;
    out_d       = out_q;
    if (hit && pend_valid_q) begin
      // a later match exists, so the held one is not the last
      out_valid_d        = 1'b1;
      out_d.status       = dqvs_pkg::ST_OK;
      out_d.position     = 5'(pend_pos_q);
      out_d.result_value = pend_val_q;
      out_d.last         = 1'b0;
    end else begin
      case (cmd_i.emit)
        dqvs_pkg::EMIT_STATUS: begin
          out_valid_d        = 1'b1;
          out_d.status       = cmd_i.status;
          out_d.position     = '0;
          out_d.result_value = '0;
          out_d.last         = 1'b1;
        end
        dqvs_pkg::EMIT_POP: begin
          out_valid_d        = 1'b1;
          out_d.status       = dqvs_pkg::ST_OK;
          out_d.position     = '0;
          out_d.result_value = rd_data_q;
          out_d.last         = 1'b1;
        end
        dqvs_pkg::EMIT_FINAL: begin
          out_valid_d = 1'b1;
          out_d.last  = 1'b1;
          if (pend_valid_q) begin
            out_d.status       = dqvs_pkg::ST_OK;
            out_d.position     = 5'(pend_pos_q);
            out_d.result_value = pend_val_q;
          end else begin
            out_d.status       = dqvs_pkg::ST_NOTFOUND;
            out_d.position     = '0;
            out_d.result_value = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q      <= '0;
      count_q      <= '0;
      off_q        <= '0;
      cmp_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      front_q     <= front_d;
      count_q     <= count_d;
      cmp_valid_q <= cmd_i.scan_issue;
      out_valid_q <= out_valid_d;
      if (cmd_i.scan_start) begin
        off_q <= '0;
      end else if (cmd_i.scan_issue) begin
        off_q <= off_q + CW'(1);
      end
      if (cmd_i.scan_start) begin
        pend_valid_q <= 1'b0;
      end else if (hit) begin
        pend_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= value_i;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
    if (cmd_i.scan_start) begin
      key_q <= value_i;
    end
    cmp_pos_q <= off_q + CW'(1);
    if (hit) begin
      pend_pos_q <= cmp_pos_q;
      pend_val_q <= rd_data_q;
    end
    out_q <= out_d;
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

`ifndef ASSERT_OFF
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.push_front || cmd_i.push_back) |=> count_q == $past(count_q) + CW'(1))
    else $error("count did not advance on push");

  a_fail_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != dqvs_pkg::ST_OK) |-> out_q.last)
    else $error("failure beat not marked last");

  a_read_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pop_front || cmd_i.pop_back || cmd_i.scan_issue) |-> count_q != '0)
    else $error("store read while empty");
`endif

endmodule

// File: rtl/core/deque_with_value_search_core.sv
// Top level of the bounded deque of signed 32-bit values with search.
//
//  channel  handshake            payload              direction
//  -------  -------------------  -------------------  ---------
//  command  start_i / busy_o     data_i   (dqvs_in_t)  in
//  result   result_valid_o       result_o (dqvs_out_t) out
//
// A command beat is taken at a clock edge with start_i high and busy_o low.
// Push, failed pop and search of an empty store: busy_o stays low and the
// result shows in the cycle after. Pop: one store read into registered data,
// then the result register. Search: the scan reads one stored entry per cycle
// over the single read port; match beats stream out during the scan, then a final beat.
// Each result beat shows for exactly one cycle; the receiver cannot stall.
// Reset clears front pointer and fill count; the store itself is not cleared.
module deque_with_value_search_core #(
  parameter int unsigned DEPTH = dqvs_pkg::DEPTH_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  dqvs_pkg::dqvs_in_t  data_i,
  output logic                result_valid_o,
  output dqvs_pkg::dqvs_out_t result_o
);

  dqvs_pkg::dqvs_cmd_t  cmd;   // sequencer commands to the datapath
  dqvs_pkg::dqvs_stat_t stat;  // full / empty / scan end back to the sequencer

  dqvs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (data_i.command),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .busy_o    (busy_o)
  );

  // store, pointers, compare and output register
  dqvs_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .value_i        (data_i.value),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
